FILE: src/vpps_pkg.sv
// Shared types and constants for the vibration pulse pattern sequencer.
package vpps_pkg;

  // Steps per bank; the step store holds two banks.
  localparam int MAX_PATTERN_STEPS = 8;
  localparam int STORE_DEPTH       = 2 * MAX_PATTERN_STEPS;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int IDX_W             = $clog2(MAX_PATTERN_STEPS + 1);

  // Configuration register indexes (word addresses on the APB port).
  localparam logic [1:0] REG_MOTOR_ENABLE = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE    = 2'd1;
  localparam logic [1:0] REG_COOLDOWN     = 2'd2;

  localparam logic [15:0] MAX_PULSE_RESET = 16'd1000;
  localparam logic [15:0] COOLDOWN_RESET  = 16'd1000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_STARTED  = 3'd1,
    ST_BAD_CNT  = 3'd2,
    ST_BUSY     = 3'd3,
    ST_COOLING  = 3'd4
  } status_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] now_ms;
    logic [2:0]  step_slot;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [3:0]  step_count;
  } item_t;

  typedef struct packed {
    logic        motor_drive;
    logic        busy_res;
    status_t     start_status;
    logic        pattern_done;
    logic [3:0]  current_step;
  } result_t;

endpackage

FILE: src/vibration_pulse_pattern_sequencer_core.sv
// Top level of the vibration pulse pattern sequencer: step store, sequencing logic, APB registers.

// The block takes one item per clock cycle, back to back, and returns exactly one result
// beat per item. The edge that accepts the item beat also reads the step store (a synchronous
// memory of two banks of steps) at the entry of the step that will be playing. The execute stage
// then evaluates the item and loads the output register when that register can take a beat.
// The read address is
// formed from the state as the item ahead leaves it, so consecutive ticks and starts need no
// bubbles; the input stalls only when the output register is full and not being taken.
// Configuration must be written through the APB port, which is always ready, only while no item is in
// flight; the block itself does not enforce this. Step entries that were never loaded must not be played.
module vibration_pulse_pattern_sequencer_core (
  input  logic                clk,
  input  logic                rst,
  // Item channel.
  input  logic                item_valid,
  output logic                item_ready,
  input  vpps_pkg::item_t     item,
  // Result channel.
  output logic                result_valid,
  input  logic                result_ready,
  output vpps_pkg::result_t   result,
  // APB configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW  = vpps_pkg::ADDR_W;
  localparam int IW  = vpps_pkg::IDX_W;
  localparam int MAX = vpps_pkg::MAX_PATTERN_STEPS;

  // Configuration registers.
  logic        motor_enable;
  logic [15:0] max_pulse_ms;
  logic [15:0] cooldown_ms;

  // Sequencer state.
  logic          active_bank, active_bank_next;
  logic [3:0]    pattern_length, pattern_length_next;
  logic [IW-1:0] step_index, step_index_next;
  logic          running, running_next;
  logic          phase_is_on, phase_is_on_next;
  logic [31:0]   phase_start_ms, phase_start_ms_next;
  logic [31:0]   last_stop_ms, last_stop_ms_next;

  // Pipeline stage holding the item whose store entry has been read.
  logic            s1_valid;
  vpps_pkg::item_t s1_item;
  logic [31:0]     rd_data;

  logic item_fire, s1_fire;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  vpps_pkg::result_t res_next;

  // Step store: on time in bits 15..0, off time in bits 31..16.
  logic [31:0] step_store [vpps_pkg::STORE_DEPTH];

  // Handshake: the execute stage advances whenever the output register can take a beat.
  assign s1_fire    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_fire;
  assign item_fire  = item_valid && item_ready;

  // APB port.
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      vpps_pkg::REG_MOTOR_ENABLE: prdata = {31'b0, motor_enable};
      vpps_pkg::REG_MAX_PULSE:    prdata = {16'b0, max_pulse_ms};
      vpps_pkg::REG_COOLDOWN:     prdata = {16'b0, cooldown_ms};
      default:                    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_enable <= 1'b0;
      max_pulse_ms <= vpps_pkg::MAX_PULSE_RESET;
      cooldown_ms  <= vpps_pkg::COOLDOWN_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        vpps_pkg::REG_MOTOR_ENABLE: motor_enable <= pwdata[0];
        vpps_pkg::REG_MAX_PULSE:    max_pulse_ms <= pwdata[15:0];
        vpps_pkg::REG_COOLDOWN:     cooldown_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Execute stage: evaluate the item against the state and the entry read for it.
  always_comb begin
    logic [31:0] elapsed;
    logic [15:0] e_on;
    logic [15:0] e_off;
    logic        finish;
    logic        step_last;
    vpps_pkg::status_t status;

    active_bank_next    = active_bank;
    pattern_length_next = pattern_length;
    step_index_next     = step_index;
    running_next        = running;
    phase_is_on_next    = phase_is_on;
    phase_start_ms_next = phase_start_ms;
    last_stop_ms_next   = last_stop_ms;
    status              = vpps_pkg::ST_NONE;
    finish              = 1'b0;
    wr_en               = 1'b0;

    elapsed   = s1_item.now_ms - phase_start_ms;
    e_on      = (rd_data[15:0] > max_pulse_ms) ? max_pulse_ms : rd_data[15:0];
    e_off     = rd_data[31:16];
    step_last = (32'(step_index) + 32'd1) >= 32'(pattern_length);

    if (s1_valid) begin
      unique case (s1_item.operation)
        vpps_pkg::OP_LOAD: begin
          wr_en = 32'(s1_item.step_slot) < 32'(MAX);
        end
        vpps_pkg::OP_START: begin
          if (motor_enable) begin
            priority if (s1_item.step_count == 4'd0 ||
                         32'(s1_item.step_count) > 32'(MAX)) begin
              status = vpps_pkg::ST_BAD_CNT;
            end else if (running) begin
              status = vpps_pkg::ST_BUSY;
            end else if ((s1_item.now_ms - last_stop_ms) < {16'b0, cooldown_ms}) begin
              status = vpps_pkg::ST_COOLING;
            end else begin
              status              = vpps_pkg::ST_STARTED;
              active_bank_next    = ~active_bank;
              pattern_length_next = s1_item.step_count;
              step_index_next     = '0;
              running_next        = 1'b1;
              phase_is_on_next    = 1'b1;
              phase_start_ms_next = s1_item.now_ms;
            end
          end
        end
        vpps_pkg::OP_TICK: begin
          if (motor_enable && running) begin
            if (phase_is_on) begin
              if (elapsed >= {16'b0, e_on}) begin
                if (e_off == 16'd0 && step_last) begin
                  finish = 1'b1;
                end else begin
                  phase_is_on_next    = 1'b0;
                  phase_start_ms_next = s1_item.now_ms;
                end
              end
            end else if (elapsed >= {16'b0, e_off}) begin
              step_index_next = step_index + 1'b1;
              if (step_last) begin
                finish = 1'b1;
              end else begin
                phase_is_on_next    = 1'b1;
                phase_start_ms_next = s1_item.now_ms;
              end
            end
          end
        end
        vpps_pkg::OP_STOP: begin
          finish = 1'b1;
        end
        default: ;
      endcase
    end

    // Finishing or stopping turns the motor off and stamps the stop time.
    if (finish) begin
      running_next      = 1'b0;
      phase_is_on_next  = 1'b0;
      last_stop_ms_next = s1_item.now_ms;
    end

    res_next.motor_drive  = running_next && phase_is_on_next;
    res_next.busy_res     = running_next;
    res_next.start_status = status;
    res_next.pattern_done = finish && running;
    res_next.current_step = 4'({{4{1'b0}}, step_index_next});
  end

  // Store addresses: loads go to the pending bank, reads follow the state the item ahead leaves.
  always_comb begin
    logic          bank_rd;
    logic [IW-1:0] idx_rd;
    bank_rd = s1_fire ? active_bank_next : active_bank;
    idx_rd  = s1_fire ? step_index_next : step_index;
    rd_addr = bank_rd ? (AW'(MAX) + AW'(idx_rd)) : AW'(idx_rd);
    wr_addr = active_bank ? AW'(s1_item.step_slot) : (AW'(MAX) + AW'(s1_item.step_slot));
  end

  // Step store memory, one write and one registered read.
  always_ff @(posedge clk) begin
    if (s1_fire && wr_en) begin
      step_store[wr_addr] <= {s1_item.off_time_ms, s1_item.on_time_ms};
    end
    if (item_fire) begin
      rd_data <= step_store[rd_addr];
    end
  end

  // Pipeline registers and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
      active_bank    <= 1'b0;
      pattern_length <= 4'd0;
      step_index     <= '0;
      running        <= 1'b0;
      phase_is_on    <= 1'b0;
      phase_start_ms <= 32'd0;
      last_stop_ms   <= 32'd0;
    end else begin
      if (item_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        result_valid   <= 1'b1;
        active_bank    <= active_bank_next;
        pattern_length <= pattern_length_next;
        step_index     <= step_index_next;
        running        <= running_next;
        phase_is_on    <= phase_is_on_next;
        phase_start_ms <= phase_start_ms_next;
        last_stop_ms   <= last_stop_ms_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_item <= item;
    end
    if (s1_fire) begin
      result <= res_next;
    end
  end

  // A running pattern always plays a step inside its length.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (32'(step_index) < 32'(pattern_length)))
    else $error("step index outside running pattern");

  // The input stalls only behind a held execute stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (s1_valid && result_valid && !result_ready))
    else $error("input stalled without a blocked result");

  // A started pattern begins on its first step with the motor on.
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.start_status == vpps_pkg::ST_STARTED) |->
      (result.motor_drive && result.busy_res && result.current_step == 4'd0))
    else $error("started result without motor on at step zero");

  // A finished pattern is no longer running.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pattern_done) |-> (!result.busy_res && !result.motor_drive))
    else $error("pattern done while still busy");

  // An accepted item reaches the execute stage on the next edge.
  a_item_enters: assert property (@(posedge clk) disable iff (rst)
    item_fire |=> s1_valid)
    else $error("accepted item lost before execute");

endmodule
